// ----- src/tfq_pkg.sv -----
// ----------------------------------------------------------------------------
// tfq_pkg - shared types and constants for the tetra face quality block
// Edge and face tables, pipeline depths and the lane result record.
// ----------------------------------------------------------------------------
package tfq_pkg;

	localparam int QW          = 32;  // result width
	localparam int LIMB        = 32;  // partial product operand width
	localparam int QUO_BITS    = 64;  // quotient bits of ratio squared
	localparam int SQRT_STEPS  = 32;  // one result bit per step
	localparam int NUM_EDGES   = 6;
	localparam int NUM_FACES   = 4;

	// edge order: ab ac ad bc bd cd
	localparam int EDGE_P [NUM_EDGES] = '{0, 0, 0, 1, 1, 2};
	localparam int EDGE_Q [NUM_EDGES] = '{1, 2, 3, 2, 3, 3};

	// faces abc abd acd bcd as edge triples
	localparam int FACE_E [NUM_FACES][3] = '{'{0, 1, 3}, '{0, 2, 4}, '{1, 2, 5}, '{3, 4, 5}};

	localparam int MUL_LAT   = 2;
	localparam int EDGE_LAT  = 3 + MUL_LAT;
	localparam int LANE_LAT  = MUL_LAT + 3 + QUO_BITS + SQRT_STEPS + 1;
	localparam int MERGE_LAT = 1;

	typedef struct packed {
		logic          vld;
		logic          deg;
		logic [QW-1:0] q;
	} lane_res_t;

endpackage

// ----- src/tfq_mul.sv -----
// ----------------------------------------------------------------------------
// tfq_mul - two stage unsigned multiplier
// Limb partial products are registered, then summed and registered.
// ----------------------------------------------------------------------------
module tfq_mul #(
	parameter int AW = 66,
	parameter int BW = 66
) (
	input  logic            clk,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);

	localparam int L  = tfq_pkg::LIMB;
	localparam int NA = (AW + L - 1) / L;
	localparam int NB = (BW + L - 1) / L;
	localparam int SW = (NA + NB) * L;

	logic [NA*L-1:0]  ax;
	logic [NB*L-1:0]  bx;
	logic [2*L-1:0]   pp_s1 [NA][NB];
	logic [SW-1:0]    acc;
	logic [AW+BW-1:0] p_s2;

	assign ax = (NA*L)'(a);
	assign bx = (NB*L)'(b);

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= (2*L)'(ax[i*L +: L]) * (2*L)'(bx[j*L +: L]);
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SW'(pp_s1[i][j]) << ((i + j) * L));
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= acc[AW+BW-1:0];
	end

	assign p = p_s2;

endmodule

// ----- src/tfq_edges.sv -----
// ----------------------------------------------------------------------------
// tfq_edges - squared edge lengths of one tetrahedron
// Offset binary coordinates, absolute deltas, squares and their sums.
// ----------------------------------------------------------------------------
module tfq_edges #(
	parameter int CW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [CW-1:0]     crd [4][3],
	output logic              out_vld,
	output logic [2*CW+1:0]   esq [tfq_pkg::NUM_EDGES]
);

	localparam int NE = tfq_pkg::NUM_EDGES;
	localparam logic [CW-1:0] SGN = {1'b1, {(CW-1){1'b0}}};

	logic [CW-1:0]   ob_s1   [4][3];
	logic [CW-1:0]   diff_s2 [NE][3];
	logic [2*CW-1:0] sq      [NE][3];
	logic [2*CW+1:0] esq_s5  [NE];
	logic            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 3; k++) begin
				ob_s1[i][k] <= crd[i][k] ^ SGN;
			end
		end
	end

	for (genvar e = 0; e < NE; e++) begin : g_edge
		localparam int P = tfq_pkg::EDGE_P[e];
		localparam int Q = tfq_pkg::EDGE_Q[e];
		for (genvar k = 0; k < 3; k++) begin : g_axis
			always_ff @(posedge clk) begin
				if (ob_s1[P][k] >= ob_s1[Q][k]) begin
					diff_s2[e][k] <= ob_s1[P][k] - ob_s1[Q][k];
				end else begin
					diff_s2[e][k] <= ob_s1[Q][k] - ob_s1[P][k];
				end
			end
			tfq_mul #(.AW(CW), .BW(CW)) u_sq (
				.clk (clk),
				.a   (diff_s2[e][k]),
				.b   (diff_s2[e][k]),
				.p   (sq[e][k])
			);
		end
		always_ff @(posedge clk) begin
			esq_s5[e] <= (2*CW+2)'(sq[e][0]) + (2*CW+2)'(sq[e][1]) + (2*CW+2)'(sq[e][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_vld = vld_s5;
	assign esq     = esq_s5;

endmodule

// ----- src/tfq_lane.sv -----
// ----------------------------------------------------------------------------
// tfq_lane - radius-edge ratio of one triangular face
// Products, Heron term, restoring divide and integer square root.
// ----------------------------------------------------------------------------
module tfq_lane #(
	parameter int SQW  = 66,
	parameter int FRAC = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [SQW-1:0]       x,
	input  logic [SQW-1:0]       y,
	input  logic [SQW-1:0]       z,
	output tfq_pkg::lane_res_t   res
);

	localparam int PW = 2 * SQW;
	localparam int DW = PW + 3;
	localparam int NW = PW + 2 * FRAC;
	localparam int QB = tfq_pkg::QUO_BITS;
	localparam int RW = DW + QB;
	localparam int SS = tfq_pkg::SQRT_STEPS;
	localparam int XW = 2 * SS;

	typedef enum logic [1:0] {
		SEL_YZ = 2'd0,
		SEL_XZ = 2'd1,
		SEL_XY = 2'd2
	} nsel_t;

	logic [PW-1:0] xy, yz, zx, xx, yy, zz;
	nsel_t         sel_s1, sel_s2;
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [DW-1:0] pos_s3, neg_s3, dd_s4;
	logic [NW-1:0] num_s3, num_s4;
	logic [PW-1:0] selp;
	logic          deg_s4;

	logic [RW-1:0] dv_rem_s [QB+1];
	logic [DW-1:0] dv_dd_s  [QB+1];
	logic [QB-1:0] dv_quo_s [QB+1];
	logic          dv_sat_s [QB+1];
	logic          dv_deg_s [QB+1];
	logic          dv_vld_s [QB+1];

	logic [XW-1:0] sq_x_s   [SS+1];
	logic [XW-1:0] sq_r_s   [SS+1];
	logic          sq_sat_s [SS+1];
	logic          sq_deg_s [SS+1];
	logic          sq_vld_s [SS+1];

	logic              out_deg_q;
	logic              out_vld_q;
	logic [tfq_pkg::QW-1:0] out_q_q;

	tfq_mul #(.AW(SQW), .BW(SQW)) u_xy (.clk(clk), .a(x), .b(y), .p(xy));
	tfq_mul #(.AW(SQW), .BW(SQW)) u_yz (.clk(clk), .a(y), .b(z), .p(yz));
	tfq_mul #(.AW(SQW), .BW(SQW)) u_zx (.clk(clk), .a(z), .b(x), .p(zx));
	tfq_mul #(.AW(SQW), .BW(SQW)) u_xx (.clk(clk), .a(x), .b(x), .p(xx));
	tfq_mul #(.AW(SQW), .BW(SQW)) u_yy (.clk(clk), .a(y), .b(y), .p(yy));
	tfq_mul #(.AW(SQW), .BW(SQW)) u_zz (.clk(clk), .a(z), .b(z), .p(zz));

	// numerator pairs the two longer edges
	always_ff @(posedge clk) begin
		if (x <= y && x <= z) begin
			sel_s1 <= SEL_YZ;
		end else if (y <= z) begin
			sel_s1 <= SEL_XZ;
		end else begin
			sel_s1 <= SEL_XY;
		end
		sel_s2 <= sel_s1;
	end

	always_comb begin
		case (sel_s2)
			SEL_YZ:  selp = yz;
			SEL_XZ:  selp = zx;
			SEL_XY:  selp = xy;
			default: selp = xy;
		endcase
	end

	always_ff @(posedge clk) begin
		pos_s3 <= (DW'(xy) + DW'(yz) + DW'(zx)) << 1;
		neg_s3 <= DW'(xx) + DW'(yy) + DW'(zz);
		num_s3 <= NW'(selp) << (2 * FRAC);
		deg_s4 <= (pos_s3 <= neg_s3);
		dd_s4  <= pos_s3 - neg_s3;
		num_s4 <= num_s3;
		dv_rem_s[0] <= RW'(num_s4);
		dv_dd_s[0]  <= dd_s4;
		dv_quo_s[0] <= '0;
		dv_deg_s[0] <= deg_s4;
		dv_sat_s[0] <= deg_s4 || (RW'(num_s4) >= (RW'(dd_s4) << QB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else begin
			vld_s1      <= in_vld;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			dv_vld_s[0] <= vld_s4;
		end
	end

	// restoring divide, one quotient bit per stage, msb first
	for (genvar g = 0; g < QB; g++) begin : g_div
		localparam int B = QB - 1 - g;
		logic [RW-1:0] trial;
		assign trial = RW'(dv_dd_s[g]) << B;
		always_ff @(posedge clk) begin
			if (dv_rem_s[g] >= trial) begin
				dv_rem_s[g+1] <= dv_rem_s[g] - trial;
				dv_quo_s[g+1] <= dv_quo_s[g] | (QB'(1) << B);
			end else begin
				dv_rem_s[g+1] <= dv_rem_s[g];
				dv_quo_s[g+1] <= dv_quo_s[g];
			end
			dv_dd_s[g+1]  <= dv_dd_s[g];
			dv_sat_s[g+1] <= dv_sat_s[g];
			dv_deg_s[g+1] <= dv_deg_s[g];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g+1] <= 1'b0;
			end else begin
				dv_vld_s[g+1] <= dv_vld_s[g];
			end
		end
	end

	assign sq_x_s[0]   = XW'(dv_quo_s[QB]);
	assign sq_r_s[0]   = '0;
	assign sq_sat_s[0] = dv_sat_s[QB];
	assign sq_deg_s[0] = dv_deg_s[QB];
	assign sq_vld_s[0] = dv_vld_s[QB];

	// digit-by-digit square root, bit walks down from 2^62
	for (genvar j = 0; j < SS; j++) begin : g_sqrt
		localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * j);
		logic [XW:0] t;
		assign t = {1'b0, sq_r_s[j]} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if ({1'b0, sq_x_s[j]} >= t) begin
				sq_x_s[j+1] <= sq_x_s[j] - t[XW-1:0];
				sq_r_s[j+1] <= (sq_r_s[j] >> 1) + BIT;
			end else begin
				sq_x_s[j+1] <= sq_x_s[j];
				sq_r_s[j+1] <= sq_r_s[j] >> 1;
			end
			sq_sat_s[j+1] <= sq_sat_s[j];
			sq_deg_s[j+1] <= sq_deg_s[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j+1] <= 1'b0;
			end else begin
				sq_vld_s[j+1] <= sq_vld_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q_q   <= sq_sat_s[SS] ? '1 : sq_r_s[SS][tfq_pkg::QW-1:0];
		out_deg_q <= sq_deg_s[SS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= sq_vld_s[SS];
		end
	end

	assign res.vld = out_vld_q;
	assign res.deg = out_deg_q;
	assign res.q   = out_q_q;

endmodule

// ----- src/tfq_merge.sv -----
// ----------------------------------------------------------------------------
// tfq_merge - combine the four face lanes
// Largest ratio and any degenerate face, registered.
// ----------------------------------------------------------------------------
module tfq_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  tfq_pkg::lane_res_t lres [tfq_pkg::NUM_FACES],
	output tfq_pkg::lane_res_t mres
);

	logic [tfq_pkg::QW-1:0] qmax;
	logic                   dany;
	logic [tfq_pkg::QW-1:0] q_q;
	logic                   deg_q;
	logic                   vld_q;

	always_comb begin
		qmax = lres[0].q;
		dany = lres[0].deg;
		for (int i = 1; i < tfq_pkg::NUM_FACES; i++) begin
			if (lres[i].q > qmax) begin
				qmax = lres[i].q;
			end
			dany = dany | lres[i].deg;
		end
	end

	always_ff @(posedge clk) begin
		q_q   <= qmax;
		deg_q <= dany;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= lres[0].vld;
		end
	end

	assign mres.vld = vld_q;
	assign mres.deg = deg_q;
	assign mres.q   = q_q;

endmodule

// ----- src/tetra_face_quality_max.sv -----
// ----------------------------------------------------------------------------
// tetra_face_quality_max - worst face radius-edge ratio of a tetrahedron
// Throughput: one request per cycle; busy stays low, nothing ever stalls.
// Depth is set by the 64-stage quotient pipe and 32-stage root pipe per lane.
// Reset: arst_n clears all valid flags at once; data registers are not reset.
// ----------------------------------------------------------------------------
module tetra_face_quality_max #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  vertex_a_x,
	input  logic signed [COORD_BITS-1:0]  vertex_a_y,
	input  logic signed [COORD_BITS-1:0]  vertex_a_z,
	input  logic signed [COORD_BITS-1:0]  vertex_b_x,
	input  logic signed [COORD_BITS-1:0]  vertex_b_y,
	input  logic signed [COORD_BITS-1:0]  vertex_b_z,
	input  logic signed [COORD_BITS-1:0]  vertex_c_x,
	input  logic signed [COORD_BITS-1:0]  vertex_c_y,
	input  logic signed [COORD_BITS-1:0]  vertex_c_z,
	input  logic signed [COORD_BITS-1:0]  vertex_d_x,
	input  logic signed [COORD_BITS-1:0]  vertex_d_y,
	input  logic signed [COORD_BITS-1:0]  vertex_d_z,
	output logic                          done,
	output logic [tfq_pkg::QW-1:0]        quality,
	output logic                          degenerate
);

	// squared edge length: three squares of COORD_BITS-wide deltas
	localparam int SQW = 2 * COORD_BITS + 2;
	localparam int NF  = tfq_pkg::NUM_FACES;
	localparam int LAT = tfq_pkg::EDGE_LAT + tfq_pkg::LANE_LAT + tfq_pkg::MERGE_LAT;

	logic [COORD_BITS-1:0] crd [4][3];
	logic                  acc;
	logic                  e_vld;
	logic [SQW-1:0]        esq [tfq_pkg::NUM_EDGES];
	tfq_pkg::lane_res_t    lres [NF];
	tfq_pkg::lane_res_t    mres;

	// the pipeline never backs up, so every request is taken
	assign busy = 1'b0;
	assign acc  = start & ~busy;

	assign crd[0][0] = vertex_a_x;
	assign crd[0][1] = vertex_a_y;
	assign crd[0][2] = vertex_a_z;
	assign crd[1][0] = vertex_b_x;
	assign crd[1][1] = vertex_b_y;
	assign crd[1][2] = vertex_b_z;
	assign crd[2][0] = vertex_c_x;
	assign crd[2][1] = vertex_c_y;
	assign crd[2][2] = vertex_c_z;
	assign crd[3][0] = vertex_d_x;
	assign crd[3][1] = vertex_d_y;
	assign crd[3][2] = vertex_d_z;

	// six shared edges, computed once for all faces
	tfq_edges #(.CW(COORD_BITS)) u_edges (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc),
		.crd     (crd),
		.out_vld (e_vld),
		.esq     (esq)
	);

	// one lane per face, all in lockstep
	for (genvar f = 0; f < NF; f++) begin : g_face
		tfq_lane #(.SQW(SQW), .FRAC(FRAC_BITS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (e_vld),
			.x      (esq[tfq_pkg::FACE_E[f][0]]),
			.y      (esq[tfq_pkg::FACE_E[f][1]]),
			.z      (esq[tfq_pkg::FACE_E[f][2]]),
			.res    (lres[f])
		);
	end

	// max of the four ratios, OR of the degenerate flags
	tfq_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.lres   (lres),
		.mres   (mres)
	);

	assign done       = mres.vld;
	assign quality    = mres.q;
	assign degenerate = mres.deg;

	// every accepted request later shows up as a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("accepted request produced no result strobe");

	// no result strobe without a matching earlier request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LAT))
		else $error("result strobe with no matching request");

	// a degenerate face forces a saturated result
	a_deg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (quality == '1))
		else $error("degenerate result not saturated");

	// lanes run in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lres[0].vld == lres[1].vld) && (lres[0].vld == lres[2].vld)
		&& (lres[0].vld == lres[3].vld))
		else $error("face lanes out of step");

endmodule
